/* sv/tfe_pkg.sv */
// Shared constants for the tagged frame escape encoder: byte width, register
// map, reset values and the tag search helper. No dependencies.
package tfe_pkg;

  localparam int BYTE_W   = 8;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;
  localparam int REG_IW   = 3;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [REG_IW-1:0] reg_idx_t;

  localparam reg_idx_t REG_DELIMITER = 3'd0;
  localparam reg_idx_t REG_ESCAPE    = 3'd1;
  localparam reg_idx_t REG_SPECIAL   = 3'd2;
  localparam reg_idx_t REG_NEWLINE   = 3'd3;
  localparam reg_idx_t REG_MASK      = 3'd4;
  localparam reg_idx_t REG_DROP      = 3'd5;

  localparam byte_t RST_DELIMITER = 8'd10;
  localparam byte_t RST_ESCAPE    = 8'd16;
  localparam byte_t RST_SPECIAL   = 8'd17;
  localparam byte_t RST_NEWLINE   = 8'd10;
  localparam byte_t RST_MASK      = 8'd128;
  localparam byte_t RST_TAG       = 8'd255;

  // At most three values are excluded, so four candidates always suffice.
  localparam int TAG_STEPS = 4;

  // Result count of one item.
  typedef logic [1:0] res_cnt_t;
  localparam res_cnt_t RES_NONE = 2'd0;
  localparam res_cnt_t RES_ONE  = 2'd1;
  localparam res_cnt_t RES_TWO  = 2'd2;

  // Pick the first of tag+1 .. tag+4 that is not an excluded value; fall
  // back to tag+4 if all are excluded.
  function automatic byte_t next_tag(byte_t tag, byte_t delim, byte_t esc,
                                     byte_t spec);
    byte_t cand;
    byte_t pick;
    logic  found;
    pick  = tag + byte_t'(TAG_STEPS);
    found = 1'b0;
    for (int i = 1; i <= TAG_STEPS; i++) begin
      cand = tag + byte_t'(i);
      if (!found && cand != delim && cand != esc && cand != spec) begin
        pick  = cand;
        found = 1'b1;
      end
    end
    return pick;
  endfunction

endpackage

/* sv/tfe_if.sv */
// Request channel interfaces of the tagged frame escape encoder: the input
// item channel and the frame byte channel. Depends on tfe_pkg.
interface tfe_in_if;
  import tfe_pkg::*;

  logic  valid;
  logic  ready;
  logic  cmd;
  byte_t data;
  logic  last;

  modport source (output valid, cmd, data, last, input ready);
  modport sink   (input valid, cmd, data, last, output ready);
endinterface

interface tfe_out_if;
  import tfe_pkg::*;

  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  out_last;

  modport source (output valid, out_byte, out_last, input ready);
  modport sink   (input valid, out_byte, out_last, output ready);
endinterface

/* sv/tagged_frame_escape_encoder.sv */
// Tagged frame escape encoder top level: input register, tag and escape
// encoding, two-byte result register. Depends on tfe_pkg and tfe_if.
//
// Usage: a header request (cmd = 0) advances the 8-bit tag past any value
// equal to the delimiter, escape or special code and emits the tag, then the
// command id. A payload request (cmd = 1) emits its byte, or the escape code
// followed by the byte ORed with mask_bits when the byte equals the newline
// or escape code. With drop_commands set the tag still advances but nothing
// is emitted. out_last marks the final byte of a request with last = 1.
// Rate: the output link moves one byte per cycle while the sink is ready; a
// dropped request never waits for the result register. An accepted request
// passes the input register, then the result register, before its first
// output byte. The input register takes a new request while the result
// register still holds bytes. Configuration must be written through the APB
// port only while no request is in flight; the block does not enforce it.
module tagged_frame_escape_encoder (
  input  logic                      clk,
  input  logic                      rst_n,
  tfe_in_if.sink                    in_ch,
  tfe_out_if.source                 out_ch,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tfe_pkg::CFG_AW-1:0] paddr,
  input  logic [tfe_pkg::CFG_DW-1:0] pwdata,
  output logic [tfe_pkg::CFG_DW-1:0] prdata,
  output logic                      pready
);
  import tfe_pkg::*;

  // Configuration registers
  byte_t delim_r, esc_r, spec_r, nl_r, mask_r;
  logic  drop_r;

  // Input register
  logic  inv_r;
  logic  cmd_r;
  byte_t data_r;
  logic  last_r;

  // Tag state
  byte_t tag_r, tag_nxt;

  // Result register: up to two bytes, shown one at a time
  res_cnt_t cnt_r, cnt_nxt;
  byte_t    b0_r, b0_nxt, b1_r, b1_nxt;
  logic     l0_r, l0_nxt, l1_r, l1_nxt;

  logic     cfg_wr;
  reg_idx_t cfg_idx;
  logic     in_fire, out_fire;
  logic     is_hdr, need_esc;
  byte_t    tag_sel;
  res_cnt_t res_n;
  byte_t    res_b0, res_b1;
  logic     res_l0;
  logic     pair_free, adv, load;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= RST_DELIMITER;
      esc_r   <= RST_ESCAPE;
      spec_r  <= RST_SPECIAL;
      nl_r    <= RST_NEWLINE;
      mask_r  <= RST_MASK;
      drop_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DELIMITER: delim_r <= pwdata[BYTE_W-1:0];
        REG_ESCAPE:    esc_r   <= pwdata[BYTE_W-1:0];
        REG_SPECIAL:   spec_r  <= pwdata[BYTE_W-1:0];
        REG_NEWLINE:   nl_r    <= pwdata[BYTE_W-1:0];
        REG_MASK:      mask_r  <= pwdata[BYTE_W-1:0];
        REG_DROP:      drop_r  <= pwdata[0];
        default: ;  // drop writes beyond the register map
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DELIMITER: prdata = CFG_DW'(delim_r);
      REG_ESCAPE:    prdata = CFG_DW'(esc_r);
      REG_SPECIAL:   prdata = CFG_DW'(spec_r);
      REG_NEWLINE:   prdata = CFG_DW'(nl_r);
      REG_MASK:      prdata = CFG_DW'(mask_r);
      REG_DROP:      prdata = CFG_DW'(drop_r);
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- input stage
  // Take a new request when the input register is empty or the held one leaves this cycle.
  assign in_ch.ready = !inv_r || adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else if (in_fire) begin
      inv_r <= 1'b1;
    end else if (adv) begin
      inv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_ch.cmd;
      data_r <= in_ch.data;
      last_r <= in_ch.last;
    end
  end

  // ---------------------------------------------------------------- encode
  assign is_hdr   = !cmd_r;
  assign need_esc = (data_r == nl_r) || (data_r == esc_r);
  assign tag_sel  = next_tag(tag_r, delim_r, esc_r, spec_r);

  always_comb begin
    if (drop_r) begin
      res_n = RES_NONE;
    end else if (is_hdr || need_esc) begin
      res_n = RES_TWO;
    end else begin
      res_n = RES_ONE;
    end
  end

  // Header: tag then id. Escaped payload: escape then masked byte.
  assign res_b0 = is_hdr ? tag_sel : (need_esc ? esc_r : data_r);
  assign res_b1 = is_hdr ? data_r : (data_r | mask_r);
  assign res_l0 = (res_n == RES_ONE) ? last_r : 1'b0;

  // Advance when the result register is empty or empties this cycle; dropped
  // requests carry no bytes and never wait.
  assign out_fire  = out_ch.valid && out_ch.ready;
  assign pair_free = (cnt_r == RES_NONE) || (cnt_r == RES_ONE && out_fire);
  assign adv       = inv_r && (res_n == RES_NONE || pair_free);
  assign load      = adv && (res_n != RES_NONE);

  assign tag_nxt = (adv && is_hdr) ? tag_sel : tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= RST_TAG;
    end else begin
      tag_r <= tag_nxt;
    end
  end

  // --------------------------------------------------------- result stage
  always_comb begin
    cnt_nxt = cnt_r;
    b0_nxt  = b0_r;
    l0_nxt  = l0_r;
    b1_nxt  = b1_r;
    l1_nxt  = l1_r;
    if (load) begin
      cnt_nxt = res_n;
      b0_nxt  = res_b0;
      l0_nxt  = res_l0;
      b1_nxt  = res_b1;
      l1_nxt  = last_r;
    end else if (out_fire) begin
      if (cnt_r == RES_TWO) begin
        // advance the second byte to the front
        cnt_nxt = RES_ONE;
        b0_nxt  = b1_r;
        l0_nxt  = l1_r;
      end else begin
        cnt_nxt = RES_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= RES_NONE;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b0_r <= b0_nxt;
    l0_r <= l0_nxt;
    b1_r <= b1_nxt;
    l1_r <= l1_nxt;
  end

  assign out_ch.valid    = (cnt_r != RES_NONE);
  assign out_ch.out_byte = b0_r;
  assign out_ch.out_last = l0_r;

  // ------------------------------------------------------------ assertions
  // A fresh tag never equals an excluded code.
  a_tag_allowed: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && is_hdr) |=> (tag_r != $past(delim_r) && tag_r != $past(esc_r) &&
                         tag_r != $past(spec_r)))
    else $error("tag took an excluded value");

  // A held request stays until it advances.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (inv_r && !adv) |=> (inv_r && $stable(data_r) && $stable(cmd_r)))
    else $error("held request lost");

  // A load never overwrites pending bytes.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (cnt_r == RES_NONE || (cnt_r == RES_ONE && out_fire)))
    else $error("result register overwritten");

  // A pending pair stays unchanged while the sink stalls.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == RES_TWO && !out_fire) |=> (cnt_r == RES_TWO && $stable(b0_r)))
    else $error("pending pair changed while stalled");

endmodule
